/* design/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg: shared definitions for the first-fit range allocator
// Table sizes, address widths, status codes, datapath commands and the
// controller state encoding.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int FREE_SLOTS = 16;
	localparam int USED_SLOTS = 16;
	localparam int ADDR_BITS  = 38;
	localparam int PAGE_BITS  = 12;
	localparam int WIDE_BITS  = ADDR_BITS + 1;
	localparam int ATTR_W     = 9;

	localparam int FIDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int UIDX_W = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
	localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
	localparam int UCNT_W = $clog2(USED_SLOTS + 1);
	localparam int SCAN_W = (FCNT_W > UCNT_W) ? FCNT_W : UCNT_W;

	localparam int CFG_REGS = 2;
	localparam int PADDR_W  = $clog2(CFG_REGS * 8);

	localparam logic [ADDR_BITS-1:0] PAGE_MASK = ADDR_BITS'((64'(1) << PAGE_BITS) - 64'(1));
	localparam logic [WIDE_BITS-1:0] SPACE_TOP_RST = WIDE_BITS'(64'(1) << ADDR_BITS);

	typedef enum logic [0:0] {
		REG_BOTTOM = 1'b0,
		REG_TOP    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_NO_FIT     = 3'd2,
		ST_NOT_FOUND  = 3'd3,
		ST_FULL       = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_REQUEST = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_LOOKUP  = 2'd2,
		KIND_INIT    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_REQ_STEP,
		OP_FREE_DROP,
		OP_PUSH_WHOLE,
		OP_PUSH_LEFT,
		OP_PUSH_RIGHT,
		OP_USED_APPEND,
		OP_USED_STEP,
		OP_TOUCH_STEP,
		OP_USED_DROP,
		OP_MERGE_STEP,
		OP_PUSH_MERGED,
		OP_INIT,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  misaligned;
		logic  fit;
		logic  f_done;
		logic  f_full;
		logic  u_done;
		logic  u_full;
		logic  u_match;
		logic  touch;
		logic  left_need;
		logic  right_need;
		logic  req_full;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_REQ_SCAN,
		S_REQ_DROP,
		S_REQ_CHECK,
		S_REQ_LEFT,
		S_REQ_RIGHT,
		S_REQ_APPEND,
		S_USED_SCAN,
		S_REL_TOUCH,
		S_REL_UDROP,
		S_REL_MERGE,
		S_REL_PUSH,
		S_INIT,
		S_DONE
	} state_t;

endpackage

/* design/ffra_ctrl.sv */
// ----------------------------------------------------------------------------
// ffra_ctrl: operation sequencer
// Steps the datapath through the scans, shifts and pushes of one operation
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module ffra_ctrl
	import ffra_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	state_t  state_q, state_d;
	status_t code_q, code_d;
	logic    out_valid_q;
	logic    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.kind)
					KIND_REQUEST: begin
						if (st.misaligned) begin
							state_d = S_DONE;
							code_d  = ST_MISALIGNED;
						end else begin
							state_d = S_REQ_SCAN;
						end
					end
					KIND_RELEASE, KIND_LOOKUP: state_d = S_USED_SCAN;
					KIND_INIT: state_d = S_INIT;
				endcase
			end
			S_REQ_SCAN: begin
				if (st.f_done) begin
					state_d = S_DONE;
					code_d  = ST_NO_FIT;
				end else if (st.fit) begin
					state_d = S_REQ_DROP;
				end
			end
			S_REQ_DROP: state_d = S_REQ_CHECK;
			S_REQ_CHECK: begin
				if (st.req_full) begin
					state_d = S_DONE;
					code_d  = ST_FULL;
				end else if (st.left_need) begin
					state_d = S_REQ_LEFT;
				end else if (st.right_need) begin
					state_d = S_REQ_RIGHT;
				end else begin
					state_d = S_REQ_APPEND;
				end
			end
			S_REQ_LEFT: state_d = st.right_need ? S_REQ_RIGHT : S_REQ_APPEND;
			S_REQ_RIGHT: state_d = S_REQ_APPEND;
			S_REQ_APPEND: begin
				state_d = S_DONE;
				code_d  = ST_OK;
			end
			S_USED_SCAN: begin
				if (st.u_done) begin
					state_d = S_DONE;
					code_d  = ST_NOT_FOUND;
				end else if (st.u_match) begin
					if (st.kind == KIND_LOOKUP) begin
						state_d = S_DONE;
						code_d  = ST_OK;
					end else begin
						state_d = S_REL_TOUCH;
					end
				end
			end
			S_REL_TOUCH: begin
				if (st.f_done) begin
					if (st.f_full && !st.touch) begin
						state_d = S_DONE;
						code_d  = ST_FULL;
					end else begin
						state_d = S_REL_UDROP;
					end
				end
			end
			S_REL_UDROP: state_d = S_REL_MERGE;
			S_REL_MERGE: begin
				if (st.f_done) begin
					state_d = S_REL_PUSH;
				end
			end
			S_REL_PUSH: begin
				state_d = S_DONE;
				code_d  = ST_OK;
			end
			S_INIT: begin
				state_d = S_DONE;
				code_d  = ST_OK;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
				end
			end
			S_DECODE: cmd.op = OP_NONE;
			S_REQ_SCAN: begin
				if (!st.f_done) begin
					cmd.op = OP_REQ_STEP;
				end
			end
			S_REQ_DROP: cmd.op = OP_FREE_DROP;
			S_REQ_CHECK: begin
				if (st.req_full) begin
					cmd.op = OP_PUSH_WHOLE;
				end
			end
			S_REQ_LEFT: cmd.op = OP_PUSH_LEFT;
			S_REQ_RIGHT: cmd.op = OP_PUSH_RIGHT;
			S_REQ_APPEND: cmd.op = OP_USED_APPEND;
			S_USED_SCAN: begin
				if (!st.u_done) begin
					cmd.op = OP_USED_STEP;
				end
			end
			S_REL_TOUCH: begin
				if (!st.f_done) begin
					cmd.op = OP_TOUCH_STEP;
				end
			end
			S_REL_UDROP: cmd.op = OP_USED_DROP;
			S_REL_MERGE: begin
				if (!st.f_done) begin
					cmd.op = OP_MERGE_STEP;
				end
			end
			S_REL_PUSH: cmd.op = OP_PUSH_MERGED;
			S_INIT: cmd.op = OP_INIT;
			S_DONE: begin
				if (out_free) begin
					cmd.op = OP_RESULT;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

/* design/ffra_dp.sv */
// ----------------------------------------------------------------------------
// ffra_dp: allocator datapath
// Holds the free and used range tables, the operand registers, the scan
// index and the result register; performs one table step per command.
// ----------------------------------------------------------------------------
module ffra_dp
	import ffra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           st,
	input  logic [1:0]           kind,
	input  logic [ADDR_BITS-1:0] base,
	input  logic [WIDE_BITS-1:0] size,
	input  logic [7:0]           perm,
	input  logic                 anon,
	input  logic [WIDE_BITS-1:0] space_bottom,
	input  logic [WIDE_BITS-1:0] space_top,
	output logic [2:0]           status,
	output logic [WIDE_BITS-1:0] range_start,
	output logic [WIDE_BITS-1:0] range_end,
	output logic [7:0]           range_perm,
	output logic                 range_anon
);

	logic [WIDE_BITS-1:0] fs_q [FREE_SLOTS];
	logic [WIDE_BITS-1:0] fe_q [FREE_SLOTS];
	logic [WIDE_BITS-1:0] us_q [USED_SLOTS];
	logic [WIDE_BITS-1:0] ue_q [USED_SLOTS];
	logic [ATTR_W-1:0]    ua_q [USED_SLOTS];
	logic [FCNT_W-1:0]    fcnt_q;
	logic [UCNT_W-1:0]    ucnt_q;
	logic [SCAN_W-1:0]    idx_q;

	kind_t                kind_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [WIDE_BITS-1:0] size_q;
	logic [7:0]           perm_q;
	logic                 anon_q;
	logic [FIDX_W-1:0]    hit_q;
	logic [UIDX_W-1:0]    uhit_q;
	logic [WIDE_BITS-1:0] s_q, e_q, nb_q, ne_q, vs_q, ve_q;
	logic [ATTR_W-1:0]    attr_q;
	logic                 touch_q;

	logic [2:0]           res_status_q;
	logic [WIDE_BITS-1:0] res_start_q, res_end_q;
	logic [7:0]           res_perm_q;
	logic                 res_anon_q;

	logic [FIDX_W-1:0]    fi, drop_idx;
	logic [UIDX_W-1:0]    ui;
	logic [WIDE_BITS-1:0] cur_s, cur_e, nb_c;
	logic [WIDE_BITS:0]   ne_sum;
	logic                 fit_c, merge_s, merge_e, do_drop, do_push;
	logic [WIDE_BITS-1:0] push_s, push_e;
	logic [1:0]           need;
	logic [WIDE_BITS-1:0] rs_c, re_c;
	logic [7:0]           rp_c;
	logic                 ra_c;

	assign fi     = idx_q[FIDX_W-1:0];
	assign ui     = idx_q[UIDX_W-1:0];
	assign cur_s  = fs_q[fi];
	assign cur_e  = fe_q[fi];
	assign nb_c   = (base_q != '0) ? {1'b0, base_q} : cur_s;
	assign ne_sum = {1'b0, nb_c} + {1'b0, size_q};
	assign fit_c  = (nb_c >= cur_s) && (ne_sum <= {1'b0, cur_e});
	assign merge_s = (cur_s == ve_q);
	assign merge_e = (cur_e == vs_q);
	assign need   = {1'b0, (nb_q > s_q)} + {1'b0, (e_q > ne_q)};

	assign do_drop  = (cmd.op == OP_FREE_DROP) ||
		((cmd.op == OP_MERGE_STEP) && (merge_s || merge_e));
	assign drop_idx = (cmd.op == OP_FREE_DROP) ? hit_q : fi;

	always_comb begin
		do_push = 1'b1;
		push_s  = vs_q;
		push_e  = ve_q;
		unique case (cmd.op)
			OP_PUSH_WHOLE: begin
				push_s = s_q;
				push_e = e_q;
			end
			OP_PUSH_LEFT: begin
				push_s = s_q;
				push_e = nb_q;
			end
			OP_PUSH_RIGHT: begin
				push_s = ne_q;
				push_e = e_q;
			end
			OP_PUSH_MERGED: begin
				push_s = vs_q;
				push_e = ve_q;
			end
			default: do_push = 1'b0;
		endcase
	end

	always_comb begin
		rs_c = '0;
		re_c = '0;
		rp_c = '0;
		ra_c = 1'b0;
		if (cmd.code == ST_OK) begin
			unique case (kind_q)
				KIND_REQUEST: begin
					rs_c = nb_q;
					re_c = ne_q;
					rp_c = perm_q;
					ra_c = anon_q;
				end
				KIND_RELEASE: begin
					rs_c = vs_q;
					re_c = ve_q;
				end
				KIND_LOOKUP: begin
					rs_c = vs_q;
					re_c = ve_q;
					rp_c = attr_q[7:0];
					ra_c = attr_q[8];
				end
				KIND_INIT: begin
					rs_c = space_bottom;
					re_c = space_top;
				end
			endcase
		end
	end

	always_comb begin
		st.kind       = kind_q;
		st.misaligned = (base_q != '0) && ((base_q & PAGE_MASK) != '0);
		st.fit        = fit_c;
		st.f_done     = idx_q >= SCAN_W'(fcnt_q);
		st.f_full     = fcnt_q >= FCNT_W'(FREE_SLOTS);
		st.u_done     = idx_q >= SCAN_W'(ucnt_q);
		st.u_full     = ucnt_q >= UCNT_W'(USED_SLOTS);
		st.u_match    = us_q[ui] == {1'b0, base_q};
		st.touch      = touch_q;
		st.left_need  = nb_q > s_q;
		st.right_need = e_q > ne_q;
		st.req_full   = ((FCNT_W + 1)'(fcnt_q) + (FCNT_W + 1)'(need) >
			(FCNT_W + 1)'(FREE_SLOTS)) || (ucnt_q >= UCNT_W'(USED_SLOTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FREE_SLOTS; k++) begin
				fs_q[k] <= '0;
				fe_q[k] <= (k == 0) ? SPACE_TOP_RST : '0;
			end
			fcnt_q  <= FCNT_W'(1);
			ucnt_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.op == OP_INIT) begin
				fs_q[0] <= space_bottom;
				fe_q[0] <= space_top;
				fcnt_q  <= FCNT_W'(1);
				ucnt_q  <= '0;
			end else if (do_drop) begin
				for (int k = 0; k < FREE_SLOTS - 1; k++) begin
					if (k >= int'(drop_idx)) begin
						fs_q[k] <= fs_q[k+1];
						fe_q[k] <= fe_q[k+1];
					end
				end
				fcnt_q <= fcnt_q - FCNT_W'(1);
			end else if (do_push && !st.f_full) begin
				for (int k = 1; k < FREE_SLOTS; k++) begin
					fs_q[k] <= fs_q[k-1];
					fe_q[k] <= fe_q[k-1];
				end
				fs_q[0] <= push_s;
				fe_q[0] <= push_e;
				fcnt_q  <= fcnt_q + FCNT_W'(1);
			end
			if (cmd.op == OP_USED_APPEND) begin
				ucnt_q <= ucnt_q + UCNT_W'(1);
			end else if (cmd.op == OP_USED_DROP) begin
				ucnt_q <= ucnt_q - UCNT_W'(1);
			end
			unique case (cmd.op)
				OP_LOAD, OP_USED_DROP: idx_q <= '0;
				OP_REQ_STEP: begin
					if (!fit_c) begin
						idx_q <= idx_q + SCAN_W'(1);
					end
				end
				OP_USED_STEP: idx_q <= st.u_match ? '0 : idx_q + SCAN_W'(1);
				OP_TOUCH_STEP: idx_q <= idx_q + SCAN_W'(1);
				OP_MERGE_STEP: idx_q <= (merge_s || merge_e) ? '0 : idx_q + SCAN_W'(1);
				default: idx_q <= idx_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q  <= kind_t'(kind);
				base_q  <= base;
				size_q  <= size;
				perm_q  <= perm;
				anon_q  <= anon;
				touch_q <= 1'b0;
			end
			OP_REQ_STEP: begin
				if (fit_c) begin
					hit_q <= fi;
					s_q   <= cur_s;
					e_q   <= cur_e;
					nb_q  <= nb_c;
					ne_q  <= ne_sum[WIDE_BITS-1:0];
				end
			end
			OP_USED_APPEND: begin
				us_q[ucnt_q[UIDX_W-1:0]] <= nb_q;
				ue_q[ucnt_q[UIDX_W-1:0]] <= ne_q;
				ua_q[ucnt_q[UIDX_W-1:0]] <= {anon_q, perm_q};
			end
			OP_USED_STEP: begin
				if (st.u_match) begin
					uhit_q <= ui;
					vs_q   <= us_q[ui];
					ve_q   <= ue_q[ui];
					attr_q <= ua_q[ui];
				end
			end
			OP_TOUCH_STEP: touch_q <= touch_q || merge_s || merge_e;
			OP_USED_DROP: begin
				for (int k = 0; k < USED_SLOTS - 1; k++) begin
					if (k >= int'(uhit_q)) begin
						us_q[k] <= us_q[k+1];
						ue_q[k] <= ue_q[k+1];
						ua_q[k] <= ua_q[k+1];
					end
				end
			end
			OP_MERGE_STEP: begin
				if (merge_s) begin
					ve_q <= cur_e;
				end else if (merge_e) begin
					vs_q <= cur_s;
				end
			end
			OP_RESULT: begin
				res_status_q <= cmd.code;
				res_start_q  <= rs_c;
				res_end_q    <= re_c;
				res_perm_q   <= rp_c;
				res_anon_q   <= ra_c;
			end
			default: touch_q <= touch_q;
		endcase
	end

	assign status      = res_status_q;
	assign range_start = res_start_q;
	assign range_end   = res_end_q;
	assign range_perm  = res_perm_q;
	assign range_anon  = res_anon_q;

endmodule

/* design/first_fit_range_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_range_allocator: first-fit range allocator with coalescing
// Input channel (in_valid/in_ready) takes one operation per transaction:
// request, release by start, lookup by start, or init of the space.
// Output channel (out_valid/out_ready) returns one result per operation.
// One operation is in work at a time; in_ready is high while the sequencer
// is idle, also while the previous result still waits in the output register.
// The sequencer walks the 16-entry tables one entry per cycle; a release
// goes back to the start of the free table after each range merge.
// If the receiver stalls, the finished result holds and the next operation
// waits in its final step until the output register is free.
// The APB port sets space_bottom (offset 0) and space_top (offset 8); they
// take effect at the next init. Reset installs the free range [0, 2^38)
// and empties the used table at once.
// ----------------------------------------------------------------------------
module first_fit_range_allocator
	import ffra_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [ADDR_BITS-1:0] base,
	input  logic [WIDE_BITS-1:0] size,
	input  logic [7:0]           perm,
	input  logic                 anon,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           status,
	output logic [WIDE_BITS-1:0] range_start,
	output logic [WIDE_BITS-1:0] range_end,
	output logic [7:0]           range_perm,
	output logic                 range_anon,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready
);

	logic [WIDE_BITS-1:0] space_bottom_q, space_top_q;
	cfg_reg_t             reg_sel;
	dp_cmd_t              cmd;
	dp_status_t           st;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_bottom_q <= '0;
			space_top_q    <= SPACE_TOP_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_BOTTOM: space_bottom_q <= pwdata[WIDE_BITS-1:0];
				REG_TOP:    space_top_q    <= pwdata[WIDE_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BOTTOM: prdata = 64'(space_bottom_q);
			REG_TOP:    prdata = 64'(space_top_q);
		endcase
	end

	ffra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ffra_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.kind         (kind),
		.base         (base),
		.size         (size),
		.perm         (perm),
		.anon         (anon),
		.space_bottom (space_bottom_q),
		.space_top    (space_top_q),
		.status       (status),
		.range_start  (range_start),
		.range_end    (range_end),
		.range_perm   (range_perm),
		.range_anon   (range_anon)
	);

`ifndef SYNTHESIS
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("New transaction accepted while an operation is in work.");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_PUSH_WHOLE || cmd.op == OP_PUSH_LEFT ||
		 cmd.op == OP_PUSH_RIGHT || cmd.op == OP_PUSH_MERGED) |-> !st.f_full)
		else $error("Free range pushed onto a full free table.");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_USED_APPEND |-> !st.u_full)
		else $error("Used range appended to a full used table.");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit range allocator
// A directed table covers the reset state, the extremes and the error codes,
// then random traffic per space setting runs against a behavioral model of
// the free and used tables. Both channels stall at random in two of three modes.
// ----------------------------------------------------------------------------
module testbench;
	import ffra_pkg::*;

	typedef struct packed {
		status_t               st;
		logic [WIDE_BITS-1:0]  rs;
		logic [WIDE_BITS-1:0]  re;
		logic [7:0]            rp;
		logic                  ra;
	} alloc_result_t;

	typedef struct {
		kind_t         k;
		logic [63:0]   b;
		logic [63:0]   s;
		logic [7:0]    p;
		logic          a;
		bit            typed;
		alloc_result_t res;
	} step_row_t;

	localparam logic [63:0] TOP38 = 64'(1) << ADDR_BITS;
	localparam logic [63:0] PG = 64'(1) << PAGE_BITS;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [ADDR_BITS-1:0] base = '0;
	logic [WIDE_BITS-1:0] size = '0;
	logic [7:0] perm = '0;
	logic anon = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] status;
	logic [WIDE_BITS-1:0] range_start, range_end;
	logic [7:0] range_perm;
	logic range_anon;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	first_fit_range_allocator uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Behavioral copy of the allocator state.
	logic [63:0] cfg_bottom, cfg_top;
	logic [63:0] free_lo[FREE_SLOTS], free_hi[FREE_SLOTS];
	int free_n;
	logic [63:0] used_lo[USED_SLOTS], used_hi[USED_SLOTS];
	logic [7:0] used_perm[USED_SLOTS];
	logic used_anon[USED_SLOTS];
	int used_n;

	alloc_result_t pending_results[$];
	int errors = 0;
	int total_items = 0;
	int idle_mode = 0;

	function automatic void install_space();
		free_lo[0] = cfg_bottom;
		free_hi[0] = cfg_top;
		free_n = 1;
		used_n = 0;
	endfunction

	function automatic void free_remove(int i);
		for (int k = i; k + 1 < free_n; k++) begin
			free_lo[k] = free_lo[k + 1];
			free_hi[k] = free_hi[k + 1];
		end
		free_n--;
	endfunction

	function automatic void free_push(logic [63:0] lo, logic [63:0] hi);
		if (free_n >= FREE_SLOTS)
			return;
		for (int k = free_n; k > 0; k--) begin
			free_lo[k] = free_lo[k - 1];
			free_hi[k] = free_hi[k - 1];
		end
		free_lo[0] = lo;
		free_hi[0] = hi;
		free_n++;
	endfunction

	function automatic int used_index(logic [63:0] start);
		for (int i = 0; i < used_n; i++)
			if (used_lo[i] == start)
				return i;
		return -1;
	endfunction

	function automatic alloc_result_t allocate_step(kind_t k, logic [63:0] b, logic [63:0] s,
			logic [7:0] p, logic a);
		alloc_result_t r;
		int hit, u, need;
		logic [63:0] nb, ne, lo, hi;
		bit touch, merged;
		r = '0;
		r.st = ST_OK;
		nb = 0;
		ne = 0;
		case (k)
			KIND_REQUEST: begin
				hit = -1;
				if (b != 0 && (b & (PG - 1)) != 0) begin
					r.st = ST_MISALIGNED;
				end else begin
					for (int i = 0; i < free_n && hit < 0; i++) begin
						nb = (b != 0) ? b : free_lo[i];
						ne = nb + s;
						if (ne >= nb && nb >= free_lo[i] && ne <= free_hi[i])
							hit = i;
					end
					if (hit < 0) begin
						r.st = ST_NO_FIT;
					end else begin
						lo = free_lo[hit];
						hi = free_hi[hit];
						need = (nb > lo) + (hi > ne);
						free_remove(hit);
						if (free_n + need > FREE_SLOTS || used_n >= USED_SLOTS) begin
							free_push(lo, hi);
							r.st = ST_FULL;
						end else begin
							if (nb > lo)
								free_push(lo, nb);
							if (hi > ne)
								free_push(ne, hi);
							used_lo[used_n] = nb;
							used_hi[used_n] = ne;
							used_perm[used_n] = p;
							used_anon[used_n] = a;
							used_n++;
							r.rs = nb;
							r.re = ne;
							r.rp = p;
							r.ra = a;
						end
					end
				end
			end
			KIND_RELEASE: begin
				u = used_index(b);
				if (u < 0) begin
					r.st = ST_NOT_FOUND;
				end else begin
					lo = used_lo[u];
					hi = used_hi[u];
					touch = 0;
					for (int i = 0; i < free_n; i++)
						if (free_lo[i] == hi || free_hi[i] == lo)
							touch = 1;
					if (free_n >= FREE_SLOTS && !touch) begin
						r.st = ST_FULL;
					end else begin
						for (int j = u; j + 1 < used_n; j++) begin
							used_lo[j] = used_lo[j + 1];
							used_hi[j] = used_hi[j + 1];
							used_perm[j] = used_perm[j + 1];
							used_anon[j] = used_anon[j + 1];
						end
						used_n--;
						merged = 1;
						while (merged) begin
							merged = 0;
							for (int i = 0; i < free_n && !merged; i++) begin
								if (free_lo[i] == hi) begin
									hi = free_hi[i];
									free_remove(i);
									merged = 1;
								end else if (free_hi[i] == lo) begin
									lo = free_lo[i];
									free_remove(i);
									merged = 1;
								end
							end
						end
						free_push(lo, hi);
						r.rs = lo;
						r.re = hi;
					end
				end
			end
			KIND_LOOKUP: begin
				u = used_index(b);
				if (u < 0) begin
					r.st = ST_NOT_FOUND;
				end else begin
					r.rs = used_lo[u];
					r.re = used_hi[u];
					r.rp = used_perm[u];
					r.ra = used_anon[u];
				end
			end
			default: begin
				install_space();
				r.rs = cfg_bottom;
				r.re = cfg_top;
			end
		endcase
		return r;
	endfunction

	task automatic send_op(kind_t k, logic [63:0] b, logic [63:0] s, logic [7:0] p, logic a,
			bit typed, alloc_result_t typed_res);
		alloc_result_t r;
		int gap;
		gap = (idle_mode == 0) ? 10 : (idle_mode == 1) ? 66 : 0;
		while ($urandom_range(0, 99) < gap) begin
			in_valid = 0;
			@(negedge clk);
		end
		kind = k;
		base = b[ADDR_BITS-1:0];
		size = s[WIDE_BITS-1:0];
		perm = p;
		anon = a;
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		r = allocate_step(k, 64'(b[ADDR_BITS-1:0]), 64'(s[WIDE_BITS-1:0]), p, a);
		pending_results.push_back(typed ? typed_res : r);
		total_items++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic apb_write(cfg_reg_t idx, logic [63:0] value);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = PADDR_W'(idx) << 3;
		pwdata = value;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		if (idx == REG_BOTTOM)
			cfg_bottom = value;
		else
			cfg_top = value;
	endtask

	task automatic random_op(logic [63:0] lo, logic [63:0] hi);
		int r;
		logic [63:0] b, s, span;
		r = $urandom_range(0, 99);
		span = (hi > lo) ? (hi - lo) >> PAGE_BITS : 0;
		b = 0;
		s = 0;
		if (r < 8) begin
			b = {$urandom, $urandom};
			s = {$urandom, $urandom} & ((64'(1) << WIDE_BITS) - 1);
			if (s > TOP38)
				s = s & (TOP38 - 1);
			send_op(kind_t'($urandom_range(0, 2)), b & (TOP38 - 1), s, 8'($urandom),
				1'($urandom), 0, '0);
		end else if (r < 58) begin
			if ($urandom_range(0, 1) && span > 0)
				b = lo + (64'($urandom_range(0, 32'(span > 64 ? 64 : span - 1))) << PAGE_BITS);
			s = 64'($urandom_range(1, 4)) << PAGE_BITS;
			case ($urandom_range(0, 19))
				0: s = 0;
				1: s = s + 64'($urandom_range(1, 4095));
				2: b = b | 64'($urandom_range(1, 4095));
				3: s = span << PAGE_BITS;
				default: ;
			endcase
			send_op(KIND_REQUEST, b & (TOP38 - 1), s, 8'($urandom), 1'($urandom), 0, '0);
		end else if (r < 97) begin
			b = (used_n > 0) ? used_lo[$urandom_range(0, used_n - 1)] : lo;
			if ($urandom_range(0, 9) == 0)
				b = b + PG;
			send_op((r < 85) ? KIND_RELEASE : KIND_LOOKUP, b & (TOP38 - 1), 0, 0, 0, 0, '0);
		end else begin
			send_op(KIND_INIT, 0, 0, 0, 0, 0, '0);
		end
	endtask

	always @(negedge clk) begin
		case (idle_mode)
			0: out_ready = $urandom_range(0, 99) >= 66;
			1: out_ready = $urandom_range(0, 99) >= 10;
			default: out_ready = 1;
		endcase
	end

	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected transaction: status %0d start %h end %h",
						status, range_start, range_end);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st || range_start !== exp_r.rs || range_end !== exp_r.re ||
						range_perm !== exp_r.rp || range_anon !== exp_r.ra) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected %0d %h %h %h %b, got %0d %h %h %h %b",
							exp_r.st, exp_r.rs, exp_r.re, exp_r.rp, exp_r.ra,
							status, range_start, range_end, range_perm, range_anon);
				end
			end
		end
	end

	step_row_t directed[$];
	logic [63:0] phase_lo[6] = '{64'h10000, 64'h0, TOP38 - 64'h20000, 64'h0, 64'h5000, 64'h0};
	logic [63:0] phase_hi[6] = '{64'h30000, TOP38, TOP38, 64'h0, 64'h1000, 64'h20000};
	int phase_items[6] = '{400, 250, 400, 60, 60, 500};

	function automatic step_row_t row(kind_t k, logic [63:0] b, logic [63:0] s, logic [7:0] p,
			logic a, bit typed, status_t st, logic [63:0] rs, logic [63:0] re, logic [7:0] rp,
			logic ra);
		step_row_t t;
		t.k = k;
		t.b = b;
		t.s = s;
		t.p = p;
		t.a = a;
		t.typed = typed;
		t.res = '{st, rs[WIDE_BITS-1:0], re[WIDE_BITS-1:0], rp, ra};
		return t;
	endfunction

	initial begin
		cfg_bottom = 0;
		cfg_top = TOP38;
		install_space();
		directed = '{
			row(KIND_LOOKUP, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0),
			row(KIND_RELEASE, 64'h1000, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0),
			row(KIND_REQUEST, 64'h123, 64'h1000, 8'hff, 1, 1, ST_MISALIGNED, 0, 0, 0, 0),
			row(KIND_REQUEST, TOP38 - 1, 64'h1000, 8'hff, 1, 1, ST_MISALIGNED, 0, 0, 0, 0),
			row(KIND_REQUEST, 0, 64'h1000, 8'hff, 1, 1, ST_OK, 0, 64'h1000, 8'hff, 1),
			row(KIND_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 0, 64'h1000, 8'hff, 1),
			row(KIND_REQUEST, 64'h3000, 64'h2000, 8'h5a, 0, 1, ST_OK, 64'h3000, 64'h5000,
				8'h5a, 0),
			row(KIND_REQUEST, 0, TOP38, 0, 0, 1, ST_NO_FIT, 0, 0, 0, 0),
			row(KIND_REQUEST, TOP38 - PG, PG, 8'h00, 1, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_REQUEST, 64'h1000, 64'h1000, 8'h3c, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_REQUEST, 0, 0, 8'h81, 1, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_RELEASE, 64'h3000, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_RELEASE, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_RELEASE, 64'h1000, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_RELEASE, TOP38 - PG, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_LOOKUP, 64'h1000, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_INIT, 0, 0, 0, 0, 1, ST_OK, 0, TOP38, 0, 0),
			row(KIND_REQUEST, 0, TOP38, 8'h81, 1, 1, ST_OK, 0, TOP38, 8'h81, 1),
			row(KIND_REQUEST, 0, 1, 0, 0, 1, ST_NO_FIT, 0, 0, 0, 0),
			row(KIND_INIT, 0, 0, 0, 0, 1, ST_OK, 0, TOP38, 0, 0),
			row(KIND_REQUEST, 64'h2aaaaaaaa000, 64'h155555555, 8'h55, 0, 0, ST_OK, 0, 0, 0, 0),
			row(KIND_REQUEST, 64'h155555554000, 64'h2aaaaaaaa, 8'haa, 1, 0, ST_OK, 0, 0, 0, 0)
		};
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (directed[i])
			send_op(directed[i].k, directed[i].b, directed[i].s, directed[i].p, directed[i].a,
				directed[i].typed, directed[i].res);
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			apb_write(REG_BOTTOM, phase_lo[ph]);
			apb_write(REG_TOP, phase_hi[ph]);
			send_op(KIND_INIT, 0, 0, 0, 0, 0, '0);
			for (int n = 0; n < phase_items[ph]; n++) begin
				idle_mode = (total_items < 580) ? 0 : (total_items < 1160) ? 1 : 2;
				random_op(phase_lo[ph], phase_hi[ph]);
			end
		end
		drain();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#50000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
